// ===== hdl/ucfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_pkg
// Shared types and constants of the serial command frame parser: byte codes,
// result kinds, command codes and the burst that one received item causes.
// ----------------------------------------------------------------------------
package ucfp_pkg;

   // longest reply burst (ticks report) and the width of a burst count
   localparam int unsigned BURST_DEPTH = 6;
   localparam int unsigned BURST_CNT_W = 3;

   // item operations
   localparam logic OP_RX          = 1'b0;
   localparam logic OP_MOTOR_DONE  = 1'b1;

   // single-byte request codes
   localparam logic [7:0] CODE_TICKS   = 8'hAE;
   localparam logic [7:0] CODE_BATTERY = 8'h11;
   localparam logic [7:0] CODE_LEFT    = 8'h7E;
   localparam logic [7:0] CODE_RIGHT   = 8'h3F;
   localparam logic [7:0] CODE_DOWN    = 8'h9A;
   localparam logic [7:0] CODE_UP      = 8'h5A;
   localparam logic [7:0] CODE_DRILL   = 8'h0F;
   localparam logic [7:0] CODE_STOP    = 8'h07;

   // transmitted status bytes
   localparam logic [7:0] BYTE_ACK        = 8'h43;
   localparam logic [7:0] BYTE_MOTOR_DONE = 8'h03;

   // frame byte count at which the checksum byte is expected
   localparam logic [1:0] FRAME_LAST = 2'd3;

   // battery scaling: clamp, then divide by 100 as (cv * 5243) >> 19
   localparam logic [14:0] BATT_MAX_CV    = 15'd25599;
   localparam logic [12:0] CV_RECIP       = 13'd5243;
   localparam int unsigned CV_RECIP_SHIFT = 19;

   typedef enum logic [1:0] {
      KIND_TX  = 2'd0,
      KIND_CMD = 2'd1,
      KIND_POS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CMD_LEFT  = 3'd0,
      CMD_RIGHT = 3'd1,
      CMD_DOWN  = 3'd2,
      CMD_UP    = 3'd3,
      CMD_DRILL = 3'd4,
      CMD_STOP  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic               op;
      logic [7:0]         rx_byte;
      logic signed [15:0] ticks_axis1;
      logic signed [15:0] ticks_axis2;
      logic [14:0]        battery_centivolts;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      cmd_type     command;
      logic [15:0] position;
   } result_type;

   typedef struct packed {
      logic [BURST_CNT_W-1:0]             count;
      result_type [BURST_DEPTH-1:0]       entries;
   } burst_type;

   // result builders
   function automatic result_type make_tx(input logic [7:0] value);
      result_type r;
      r          = '0;
      r.kind     = KIND_TX;
      r.tx_byte  = value;
      return r;
   endfunction

   function automatic result_type make_cmd(input cmd_type code);
      result_type r;
      r          = '0;
      r.kind     = KIND_CMD;
      r.command  = code;
      return r;
   endfunction

   function automatic result_type make_pos(input logic [15:0] value);
      result_type r;
      r          = '0;
      r.kind     = KIND_POS;
      r.position = value;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ucfp_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_req_if
// Item channel into the parser: one received byte or a motor-done event,
// with the current encoder counts and battery voltage.
// ----------------------------------------------------------------------------
interface ucfp_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [7:0]         rx_byte;
   logic signed [15:0] ticks_axis1;
   logic signed [15:0] ticks_axis2;
   logic [14:0]        battery_centivolts;

   modport source (
      output valid, op, rx_byte, ticks_axis1, ticks_axis2, battery_centivolts,
      input  ready
   );
   modport sink (
      input  valid, op, rx_byte, ticks_axis1, ticks_axis2, battery_centivolts,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/ucfp_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_rsp_if
// Result channel out of the parser: transmit byte, motion command or
// target position, with a flag on the final result of an item.
// ----------------------------------------------------------------------------
interface ucfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  tx_byte;
   logic [2:0]  command;
   logic [15:0] position;
   logic        last;

   modport source (
      output valid, kind, tx_byte, command, position, last,
      input  ready
   );
   modport sink (
      input  valid, kind, tx_byte, command, position, last,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/ucfp_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_decode
// Input register and single-pass decoder. Holds the frame state and turns
// the registered item into a burst of up to six results.
// ----------------------------------------------------------------------------
module ucfp_decode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire ucfp_pkg::req_type  in_item,
   output logic                    burst_valid,
   input  wire logic               burst_ready,
   output ucfp_pkg::burst_type     burst
);
   import ucfp_pkg::*;

   logic              valid_ff, valid_in;
   req_type           item_ff;
   logic [1:0]        count_ff, count_in;
   logic [2:0][7:0]   frame_ff, frame_in;
   logic              advance;

   logic [7:0]        rx;
   logic [7:0]        t1_hi, t1_lo, t2_hi, t2_lo, ticks_sum;
   logic [14:0]       cv_sat;
   logic [27:0]       cv_prod;
   logic [7:0]        volts;
   logic [14:0]       volts_x100;
   logic [14:0]       cv_rem;
   logic [7:0]        hundredths;
   logic [7:0]        frame_sum;

   // input register handshake
   assign advance     = valid_ff && burst_ready;
   assign in_ready    = !valid_ff || burst_ready;
   assign burst_valid = valid_ff;
   assign valid_in    = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            count_ff <= count_in;
         end
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
      if (advance) begin
         frame_ff <= frame_in;
      end
   end

   // report bytes
   always_comb begin
      rx         = item_ff.rx_byte;
      t1_hi      = item_ff.ticks_axis1[15:8];
      t1_lo      = item_ff.ticks_axis1[7:0];
      t2_hi      = item_ff.ticks_axis2[15:8];
      t2_lo      = item_ff.ticks_axis2[7:0];
      ticks_sum  = CODE_TICKS + t1_hi + t1_lo + t2_hi + t2_lo;
      cv_sat     = (item_ff.battery_centivolts > BATT_MAX_CV) ? BATT_MAX_CV
                                                              : item_ff.battery_centivolts;
      cv_prod    = 28'(cv_sat) * 28'(CV_RECIP);
      volts      = cv_prod[CV_RECIP_SHIFT +: 8];
      // times 100 as 64 + 32 + 4
      volts_x100 = {1'b0, volts, 6'b0} + {2'b0, volts, 5'b0} + {5'b0, volts, 2'b0};
      cv_rem     = cv_sat - volts_x100;
      hundredths = cv_rem[7:0];
      frame_sum  = frame_ff[0] + frame_ff[1] + frame_ff[2];
   end

   // burst decode and frame state update
   always_comb begin
      burst    = '0;
      count_in = count_ff;
      frame_in = frame_ff;
      priority if (item_ff.op == OP_MOTOR_DONE) begin
         burst.entries[0] = make_tx(BYTE_MOTOR_DONE);
         burst.count      = 3'd1;
      end else if (count_ff == '0 && rx == CODE_TICKS) begin
         burst.entries[0] = make_tx(CODE_TICKS);
         burst.entries[1] = make_tx(t1_hi);
         burst.entries[2] = make_tx(t1_lo);
         burst.entries[3] = make_tx(t2_hi);
         burst.entries[4] = make_tx(t2_lo);
         burst.entries[5] = make_tx(ticks_sum);
         burst.count      = 3'd6;
      end else if (count_ff == '0 && rx == CODE_BATTERY) begin
         burst.entries[0] = make_tx(CODE_BATTERY);
         burst.entries[1] = make_tx(volts);
         burst.entries[2] = make_tx(hundredths);
         burst.entries[3] = make_tx(8'(CODE_BATTERY + volts + hundredths));
         burst.count      = 3'd4;
      end else if (count_ff == '0 && rx == CODE_LEFT) begin
         burst.entries[0] = make_cmd(CMD_LEFT);
         burst.count      = 3'd1;
      end else if (count_ff == '0 && rx == CODE_RIGHT) begin
         burst.entries[0] = make_cmd(CMD_RIGHT);
         burst.count      = 3'd1;
      end else if (count_ff == '0 && rx == CODE_DOWN) begin
         burst.entries[0] = make_cmd(CMD_DOWN);
         burst.count      = 3'd1;
      end else if (count_ff == '0 && rx == CODE_UP) begin
         burst.entries[0] = make_cmd(CMD_UP);
         burst.count      = 3'd1;
      end else if (count_ff == '0 && rx == CODE_DRILL) begin
         burst.entries[0] = make_cmd(CMD_DRILL);
         burst.count      = 3'd1;
      end else if (count_ff == '0 && rx == CODE_STOP) begin
         burst.entries[0] = make_cmd(CMD_STOP);
         burst.count      = 3'd1;
      end else if (count_ff != FRAME_LAST) begin
         // store a frame byte
         for (int i = 0; i < 3; i++) begin
            if (count_ff == 2'(i)) begin
               frame_in[i] = rx;
            end
         end
         count_in = count_ff + 2'd1;
      end else begin
         // checksum byte closes the frame
         count_in = '0;
         if (frame_sum == rx) begin
            burst.entries[0] = make_pos({frame_ff[1], frame_ff[2]});
            burst.entries[1] = make_tx(BYTE_ACK);
            burst.count      = 3'd2;
         end
      end
   end

   // a checksum byte always closes the frame
   a_frame_closes: assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.op == OP_RX && count_ff == FRAME_LAST |=> count_ff == '0)
      else $error("frame not closed after checksum byte");

endmodule
`default_nettype wire

// ===== hdl/ucfp_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_emit
// Result register: takes a whole burst from the decoder and shifts it out,
// one result per transfer, flagging the final one.
// ----------------------------------------------------------------------------
module ucfp_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 burst_valid,
   output logic                      burst_ready,
   input  wire ucfp_pkg::burst_type  burst,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output ucfp_pkg::result_type      out_result,
   output logic                      out_last
);
   import ucfp_pkg::*;

   logic [BURST_CNT_W-1:0]        count_ff, count_in;
   result_type [BURST_DEPTH-1:0]  entries_ff, entries_in;
   logic                          take;
   logic                          load;

   // handshake on both sides
   assign out_valid   = count_ff != '0;
   assign take        = out_valid && out_ready;
   assign burst_ready = (count_ff == '0) || (count_ff == BURST_CNT_W'(1) && take);
   assign load        = burst_valid && burst_ready && burst.count != '0;
   assign out_result  = entries_ff[0];
   assign out_last    = count_ff == BURST_CNT_W'(1);

   // shift on transfer, reload from the decoder
   always_comb begin
      count_in   = count_ff;
      entries_in = entries_ff;
      if (take) begin
         for (int i = 0; i < BURST_DEPTH - 1; i++) begin
            entries_in[i] = entries_ff[i+1];
         end
         count_in = count_ff - BURST_CNT_W'(1);
      end
      if (load) begin
         entries_in = burst.entries;
         count_in   = burst.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BURST_CNT_W'(BURST_DEPTH))
      else $error("burst count beyond depth");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> $stable(count_ff) && $stable(entries_ff[0]))
      else $error("pending result changed during stall");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> count_ff == $past(burst.count))
      else $error("loaded burst count lost");

endmodule
`default_nettype wire

// ===== hdl/uart_command_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_frame_parser
// Parses received serial bytes into reports, motion commands and target
// positions from checksummed four-byte frames.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  req_bus   in   op, rx_byte, ticks_axis1, ticks_axis2, battery_centivolts
//  rsp_bus   out  kind, tx_byte, command, position, last
//
//  an item is decoded in one pass between the input register and the result
//  register; its burst of up to six results then leaves one per cycle while
//  rsp_bus.ready is high, and a new item is taken every cycle while bursts
//  are one result long and it stays high; a burst of n results holds the
//  result register until all n are taken (six for a ticks report)
//  frame bytes that cause no result still pass the input register in order
//  synchronous reset clears the frame byte count and both handshake stages
// ----------------------------------------------------------------------------
module uart_command_frame_parser (
   input  wire logic   clock,
   input  wire logic   reset,
   ucfp_req_if.sink    req_bus,
   ucfp_rsp_if.source  rsp_bus
);
   import ucfp_pkg::*;

   req_type     req_item;
   burst_type   burst;
   logic        burst_valid;
   logic        burst_ready;
   result_type  rsp_result;

   // gather the request payload
   always_comb begin
      req_item.op                 = req_bus.op;
      req_item.rx_byte            = req_bus.rx_byte;
      req_item.ticks_axis1        = req_bus.ticks_axis1;
      req_item.ticks_axis2        = req_bus.ticks_axis2;
      req_item.battery_centivolts = req_bus.battery_centivolts;
   end

   ucfp_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .in_item     (req_item),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst)
   );

   ucfp_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_result  (rsp_result),
      .out_last    (rsp_bus.last)
   );

   // spread the result payload
   assign rsp_bus.kind     = rsp_result.kind;
   assign rsp_bus.tx_byte  = rsp_result.tx_byte;
   assign rsp_bus.command  = rsp_result.command;
   assign rsp_bus.position = rsp_result.position;

endmodule
`default_nettype wire

// ===== bench/uart_command_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_command_frame_parser_tb
// Drives received bytes and motor-done events into the parser with random
// gaps on both channels. It predicts every reply burst in step with each
// accepted transfer and checks each result field by field against the
// oldest prediction. It covers request codes, framing rules, checksums and
// the battery clamp.
// ----------------------------------------------------------------------------
module uart_command_frame_parser_tb;
   import ucfp_pkg::*;

   // one predicted result of the parser
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      cmd_type     command;
      logic [15:0] position;
      logic        last;
   } reply_type;

   logic clock = 1'b0;
   logic reset;

   ucfp_req_if req_bus ();
   ucfp_rsp_if rsp_bus ();

   uart_command_frame_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // parser state as predicted
   logic [1:0]  frame_count = 2'd0;
   logic [7:0]  frame_held [3] = '{8'h00, 8'h00, 8'h00};

   reply_type   reply_fifo [$];
   reply_type   oldest_reply;
   int          error_count = 0;
   int          items_sent  = 0;
   bit          no_idle     = 1'b0;

   logic [7:0]  request_codes [8] = '{CODE_TICKS, CODE_BATTERY, CODE_LEFT, CODE_RIGHT,
                                      CODE_DOWN, CODE_UP, CODE_DRILL, CODE_STOP};

   always #4 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic bit is_request_code(input logic [7:0] value);
      foreach (request_codes[i])
         if (request_codes[i] == value) return 1'b1;
      return 1'b0;
   endfunction

   function automatic reply_type reply_of(input kind_type k, input logic [7:0] value,
                                          input cmd_type code, input logic [15:0] pos);
      reply_type r;
      r.kind     = k;
      r.tx_byte  = value;
      r.command  = code;
      r.position = pos;
      r.last     = 1'b0;
      return r;
   endfunction

   // predict the reply burst of one accepted item and advance the frame state
   function automatic void parse_serial_item(input req_type item);
      reply_type   burst [$];
      logic [7:0]  report [6];
      logic [7:0]  sum;
      logic [14:0] cv;
      logic [7:0]  volts;
      logic [7:0]  hundredths;
      bit          handled;
      handled = 1'b0;
      if (item.op == OP_MOTOR_DONE) begin
         burst.push_back(reply_of(KIND_TX, BYTE_MOTOR_DONE, CMD_LEFT, 16'h0000));
         handled = 1'b1;
      end else if (frame_count == 2'd0) begin
         handled = 1'b1;
         case (item.rx_byte)
            CODE_TICKS: begin
               report[0] = CODE_TICKS;
               report[1] = item.ticks_axis1[15:8];
               report[2] = item.ticks_axis1[7:0];
               report[3] = item.ticks_axis2[15:8];
               report[4] = item.ticks_axis2[7:0];
               sum = 8'h00;
               for (int i = 0; i < 5; i++) sum = sum + report[i];
               report[5] = sum;
               for (int i = 0; i < 6; i++)
                  burst.push_back(reply_of(KIND_TX, report[i], CMD_LEFT, 16'h0000));
            end
            CODE_BATTERY: begin
               cv = (item.battery_centivolts > BATT_MAX_CV) ? BATT_MAX_CV
                                                            : item.battery_centivolts;
               volts      = 8'(cv / 15'd100);
               hundredths = 8'(cv % 15'd100);
               sum        = CODE_BATTERY + volts + hundredths;
               burst.push_back(reply_of(KIND_TX, CODE_BATTERY, CMD_LEFT, 16'h0000));
               burst.push_back(reply_of(KIND_TX, volts, CMD_LEFT, 16'h0000));
               burst.push_back(reply_of(KIND_TX, hundredths, CMD_LEFT, 16'h0000));
               burst.push_back(reply_of(KIND_TX, sum, CMD_LEFT, 16'h0000));
            end
            CODE_LEFT:  burst.push_back(reply_of(KIND_CMD, 8'h00, CMD_LEFT, 16'h0000));
            CODE_RIGHT: burst.push_back(reply_of(KIND_CMD, 8'h00, CMD_RIGHT, 16'h0000));
            CODE_DOWN:  burst.push_back(reply_of(KIND_CMD, 8'h00, CMD_DOWN, 16'h0000));
            CODE_UP:    burst.push_back(reply_of(KIND_CMD, 8'h00, CMD_UP, 16'h0000));
            CODE_DRILL: burst.push_back(reply_of(KIND_CMD, 8'h00, CMD_DRILL, 16'h0000));
            CODE_STOP:  burst.push_back(reply_of(KIND_CMD, 8'h00, CMD_STOP, 16'h0000));
            default:    handled = 1'b0;
         endcase
      end
      // ordinary frame byte, or the checksum byte that closes the frame
      if (!handled) begin
         if (frame_count < FRAME_LAST) begin
            frame_held[frame_count] = item.rx_byte;
            frame_count = frame_count + 2'd1;
         end else begin
            sum = frame_held[0] + frame_held[1] + frame_held[2];
            frame_count = 2'd0;
            if (sum == item.rx_byte) begin
               burst.push_back(reply_of(KIND_POS, 8'h00, CMD_LEFT,
                                        {frame_held[1], frame_held[2]}));
               burst.push_back(reply_of(KIND_TX, BYTE_ACK, CMD_LEFT, 16'h0000));
            end
         end
      end
      if (burst.size() != 0) begin
         burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) reply_fifo.push_back(burst[i]);
      end
   endfunction

   function automatic req_type serial_byte(input logic [7:0] value);
      req_type it;
      it.op                 = OP_RX;
      it.rx_byte            = value;
      it.ticks_axis1        = 16'($urandom);
      it.ticks_axis2        = 16'($urandom);
      it.battery_centivolts = 15'($urandom_range(0, 32767));
      return it;
   endfunction

   function automatic req_type motor_done_event();
      req_type it;
      it         = serial_byte(8'($urandom));
      it.op      = OP_MOTOR_DONE;
      return it;
   endfunction

   // one input transfer after a random gap; prediction runs at acceptance
   task automatic send_item(input req_type item);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid              <= 1'b1;
      req_bus.op                 <= item.op;
      req_bus.rx_byte            <= item.rx_byte;
      req_bus.ticks_axis1        <= item.ticks_axis1;
      req_bus.ticks_axis2        <= item.ticks_axis2;
      req_bus.battery_centivolts <= item.battery_centivolts;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      parse_serial_item(item);
      items_sent++;
   endtask

   // hold the sender until every predicted result has come out
   task automatic wait_for_replies();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (reply_fifo.size() != 0) @(posedge clock);
   endtask

   // every single-byte code, tick extremes and the battery clamp
   task automatic test_request_codes();
      req_type it;
      it = serial_byte(CODE_TICKS);
      it.ticks_axis1 = 16'sh7FFF;
      it.ticks_axis2 = 16'sh8000;
      send_item(it);
      it = serial_byte(CODE_TICKS);
      it.ticks_axis1 = 16'shFFFF;
      it.ticks_axis2 = 16'sh0000;
      send_item(it);
      it = serial_byte(CODE_BATTERY);
      it.battery_centivolts = 15'd0;
      send_item(it);
      it.battery_centivolts = BATT_MAX_CV;
      send_item(it);
      it.battery_centivolts = 15'h7FFF;
      send_item(it);
      for (int i = 2; i < 8; i++) send_item(serial_byte(request_codes[i]));
   endtask

   // code bytes inside a frame, motor-done mid-frame, bad checksum, extremes
   task automatic test_frame_rules();
      send_item(serial_byte(8'h01));
      send_item(serial_byte(CODE_TICKS));
      send_item(motor_done_event());
      send_item(serial_byte(CODE_STOP));
      send_item(serial_byte(8'hB6));
      // dropped frame, then a code must be taken as a request again
      send_item(serial_byte(8'h20));
      send_item(serial_byte(8'h30));
      send_item(serial_byte(8'h40));
      send_item(serial_byte(8'h91));
      send_item(serial_byte(CODE_UP));
      send_item(serial_byte(8'hFF));
      send_item(serial_byte(8'hFF));
      send_item(serial_byte(8'hFF));
      send_item(serial_byte(8'hFD));
   endtask

   // mostly well-formed frames with random content, plus codes, events, noise
   task automatic test_random_traffic(input int count, input bit quiet);
      int         stop_at;
      int         sel;
      logic [7:0] first;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] check;
      no_idle = quiet;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            while (frame_count != 2'd0) send_item(serial_byte(8'($urandom)));
            do first = 8'($urandom); while (is_request_code(first));
            b1    = 8'($urandom);
            b2    = 8'($urandom);
            check = first + b1 + b2;
            if (sel >= 45) check = check + 8'($urandom_range(1, 255));
            send_item(serial_byte(first));
            send_item(serial_byte(b1));
            if ($urandom_range(0, 9) == 0) send_item(motor_done_event());
            send_item(serial_byte(b2));
            send_item(serial_byte(check));
         end else if (sel < 75) begin
            send_item(serial_byte(request_codes[$urandom_range(0, 7)]));
         end else if (sel < 85) begin
            send_item(motor_done_event());
         end else begin
            send_item(serial_byte(8'($urandom)));
         end
      end
      no_idle = 1'b0;
   endtask

   // result receiver with a random stall before each result
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (reply_fifo.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: kind %0d tx %h cmd %0d pos %h last %b",
                        rsp_bus.kind, rsp_bus.tx_byte, rsp_bus.command,
                        rsp_bus.position, rsp_bus.last);
         end else begin
            oldest_reply = reply_fifo.pop_front();
            if (rsp_bus.kind !== oldest_reply.kind || rsp_bus.tx_byte !== oldest_reply.tx_byte
                || rsp_bus.command !== oldest_reply.command
                || rsp_bus.position !== oldest_reply.position
                || rsp_bus.last !== oldest_reply.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected kind %0d tx %h cmd %0d pos %h last %b, %s",
                           oldest_reply.kind, oldest_reply.tx_byte, oldest_reply.command,
                           oldest_reply.position, oldest_reply.last,
                           $sformatf("got kind %0d tx %h cmd %0d pos %h last %b",
                                     rsp_bus.kind, rsp_bus.tx_byte, rsp_bus.command,
                                     rsp_bus.position, rsp_bus.last));
            end
         end
      end
   end

   // reset, test sequence and final verdict
   initial begin
      reset                      = 1'b1;
      req_bus.valid              = 1'b0;
      req_bus.op                 = OP_RX;
      req_bus.rx_byte            = 8'h00;
      req_bus.ticks_axis1        = 16'sh0000;
      req_bus.ticks_axis2        = 16'sh0000;
      req_bus.battery_centivolts = 15'd0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_request_codes();
      wait_for_replies();
      test_frame_rules();
      wait_for_replies();
      test_random_traffic(100, 1'b1);
      wait_for_replies();
      test_random_traffic(300, 1'b0);

      wait_for_replies();
      repeat (16) @(posedge clock);
      if (reply_fifo.size() != 0) begin
         error_count += reply_fifo.size();
         $display("%0d predicted results never arrived", reply_fifo.size());
      end
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
